// File: hdl/ccie_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package ccie_pkg;

    localparam int WIDTH      = 32;
    localparam int MAX_PRIMES = 9;
    localparam int CNT_W      = $clog2(MAX_PRIMES + 1);
    localparam int IDX_W      = (MAX_PRIMES > 1) ? $clog2(MAX_PRIMES) : 1;
    localparam int SUB_W      = MAX_PRIMES + 1;
    localparam int STEP_W     = $clog2(WIDTH + 1);

    // Divider request and response
    typedef struct packed {
        logic             start;
        logic [WIDTH-1:0] dividend;
        logic [WIDTH-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [WIDTH-1:0] quot;
        logic [WIDTH-1:0] rem;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TEST_REQ,
        ST_TEST_WAIT,
        ST_OUT_REQ,
        ST_OUT_WAIT,
        ST_LAST,
        ST_SUB_START,
        ST_MUL,
        ST_DIV_REQ,
        ST_DIV_WAIT,
        ST_FINISH
    } state_t;

endpackage
`default_nettype wire

// File: hdl/ccie_div.sv
`timescale 1ns / 1ps
`default_nettype none
module ccie_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire ccie_pkg::div_req_t req,
    output ccie_pkg::div_rsp_t     rsp
);
    import ccie_pkg::*;

    logic [WIDTH-1:0]  quot_reg, quot_next;
    logic [WIDTH-1:0]  rem_reg, rem_next;
    logic [WIDTH-1:0]  dvs_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg, done_reg;
    logic [WIDTH:0]    trial;
    logic              fits;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial     = {rem_reg, quot_reg[WIDTH-1]};
        fits      = trial >= {1'b0, dvs_reg};
        rem_next  = fits ? WIDTH'(trial - {1'b0, dvs_reg}) : trial[WIDTH-1:0];
        quot_next = {quot_reg[WIDTH-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                quot_reg <= req.dividend;
                rem_reg  <= '0;
                dvs_reg  <= req.divisor;
                step_reg <= '0;
            end else if (busy_reg) begin
                quot_reg <= quot_next;
                rem_reg  <= rem_next;
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(WIDTH - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;
    assign rsp.rem  = rem_reg;

endmodule
`default_nettype wire

// File: hdl/coprime_count_inclusion_exclusion_unit.sv
// Sequence: trial division runs one divide per candidate divisor up to the square
// root of the modulus (plus one per factor divided out); then each of the 2^k - 1
// prime subsets takes a setup step, a multiply pass over the k primes and one divide.
// Throughput: one item at a time; a new item is taken once the result is posted.
// Reset: aresetn synchronous, active low; clears the sequencer and output valid.
`timescale 1ns / 1ps
`default_nettype none
module coprime_count_inclusion_exclusion_unit (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [ccie_pkg::WIDTH-1:0] s_modulus,
    input  wire logic [ccie_pkg::WIDTH-1:0] s_limit,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [ccie_pkg::WIDTH-1:0]      m_coprime_count
);
    import ccie_pkg::*;

    state_t            state_reg, state_next;
    logic [WIDTH-1:0]  n_reg, r_reg, d_reg, prod_reg, sum_reg, out_reg;
    logic [WIDTH-1:0]  prime_reg [MAX_PRIMES];
    logic [CNT_W-1:0]  cnt_reg, i_reg;
    logic [SUB_W-1:0]  subset_reg;
    logic              par_reg, m_valid_reg;
    logic [WIDTH-1:0]  mul_full;
    logic              out_free, subsets_done;
    div_req_t          dreq;
    div_rsp_t          drsp;

    ccie_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    assign out_free     = !m_valid_reg || m_ready;
    assign subsets_done = subset_reg == (SUB_W'(1) << cnt_reg);
    assign mul_full     = prod_reg * prime_reg[i_reg[IDX_W-1:0]];

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:      if (s_valid) state_next = ST_TEST_REQ;
            ST_TEST_REQ:  state_next = ST_TEST_WAIT;
            ST_TEST_WAIT: begin
                if (drsp.done) begin
                    if (d_reg > drsp.quot)      state_next = ST_LAST;
                    else if (drsp.rem == '0)    state_next = ST_OUT_REQ;
                    else                        state_next = ST_TEST_REQ;
                end
            end
            ST_OUT_REQ:   state_next = ST_OUT_WAIT;
            ST_OUT_WAIT: begin
                if (drsp.done) begin
                    state_next = (drsp.rem == '0) ? ST_OUT_REQ : ST_TEST_REQ;
                end
            end
            ST_LAST:      state_next = ST_SUB_START;
            ST_SUB_START: state_next = subsets_done ? ST_FINISH : ST_MUL;
            ST_MUL:       if (i_reg == cnt_reg) state_next = ST_DIV_REQ;
            ST_DIV_REQ:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:  if (drsp.done) state_next = ST_SUB_START;
            ST_FINISH:    if (out_free) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        s_ready       = state_reg == ST_IDLE;
        dreq.start    = 1'b0;
        dreq.dividend = n_reg;
        dreq.divisor  = d_reg;
        case (state_reg)
            ST_TEST_REQ, ST_OUT_REQ: dreq.start = 1'b1;
            ST_DIV_REQ: begin
                dreq.start    = 1'b1;
                dreq.dividend = r_reg;
                dreq.divisor  = prod_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // Post the result, or drop valid once it is taken
            if (state_reg == ST_FINISH && out_free) m_valid_reg <= 1'b1;
            else if (m_valid_reg && m_ready)        m_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                n_reg   <= s_modulus;
                r_reg   <= s_limit;
                d_reg   <= WIDTH'(2);
                cnt_reg <= '0;
            end
            ST_TEST_WAIT: begin
                if (drsp.done && d_reg <= drsp.quot) begin
                    if (drsp.rem == '0) begin
                        if (cnt_reg < CNT_W'(MAX_PRIMES)) begin
                            prime_reg[cnt_reg[IDX_W-1:0]] <= d_reg;
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                        n_reg <= drsp.quot;
                    end else begin
                        d_reg <= d_reg + 1'b1;
                    end
                end
            end
            ST_OUT_WAIT: begin
                if (drsp.done) begin
                    if (drsp.rem == '0) n_reg <= drsp.quot;
                    else                d_reg <= d_reg + 1'b1;
                end
            end
            ST_LAST: begin
                // Leftover above one is the last prime
                if (n_reg > WIDTH'(1) && cnt_reg < CNT_W'(MAX_PRIMES)) begin
                    prime_reg[cnt_reg[IDX_W-1:0]] <= n_reg;
                    cnt_reg <= cnt_reg + 1'b1;
                end
                subset_reg <= SUB_W'(1);
                sum_reg    <= '0;
            end
            ST_SUB_START: begin
                prod_reg <= WIDTH'(1);
                i_reg    <= '0;
                par_reg  <= 1'b0;
            end
            ST_MUL: begin
                if (i_reg != cnt_reg) begin
                    if (subset_reg[i_reg]) begin
                        prod_reg <= mul_full;
                        par_reg  <= !par_reg;
                    end
                    i_reg <= i_reg + 1'b1;
                end
            end
            ST_DIV_WAIT: begin
                if (drsp.done) begin
                    sum_reg    <= par_reg ? sum_reg + drsp.quot : sum_reg - drsp.quot;
                    subset_reg <= subset_reg + 1'b1;
                end
            end
            ST_FINISH: begin
                if (out_free) out_reg <= r_reg - sum_reg;
            end
            default: ;
        endcase
    end

    assign m_valid         = m_valid_reg;
    assign m_coprime_count = out_reg;

endmodule
`default_nettype wire

// File: hdl/ccie_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module ccie_checker (
    input wire logic                       aclk,
    input wire logic                       aresetn,
    input wire logic                       s_valid,
    input wire logic                       s_ready,
    input wire logic                       m_valid,
    input wire logic                       m_ready,
    input wire logic [ccie_pkg::WIDTH-1:0] m_coprime_count
);
    // Busy right after taking an item
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("ready stayed high after input transfer");

    // Stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_coprime_count))
        else $error("stalled result changed");

    // Reset leaves no result pending
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // A result never appears the cycle after an input transfer
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid)
        else $error("result posted too early");
endmodule

bind coprime_count_inclusion_exclusion_unit ccie_checker u_ccie_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_coprime_count (m_coprime_count)
);
`default_nettype wire
